[hdl/crc8_packet_frame_checker_unit_assert.svh]
// Assertion macros shared by the checker modules.
`ifndef CRC8_PACKET_FRAME_CHECKER_UNIT_ASSERT_SVH
`define CRC8_PACKET_FRAME_CHECKER_UNIT_ASSERT_SVH

// Check on every rising edge outside reset.
`define CRC8PFC_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Check on every rising edge, reset included.
`define CRC8PFC_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

[hdl/crc8pfc_pkg.sv]
package crc8pfc_pkg;

   localparam logic [7:0] HDR_FULL = 8'hF0;
   localparam logic [7:0] HDR_NEG  = 8'hB0;
   localparam logic [7:0] HDR_ACK  = 8'hA0;
   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_INIT = 8'hFF;
   localparam logic [8:0] COUNT_MAX = 9'd511;

   localparam logic [8:0] PAYLOAD_START  = 9'd4;
   localparam logic [9:0] FULL_OVERHEAD  = 10'd5;
   localparam logic [9:0] FULL_MIN_TOTAL = 10'd6;
   localparam logic [9:0] MIN_TOTAL      = 10'd2;

   localparam logic [1:0] ST_OK  = 2'd0;
   localparam logic [1:0] ST_ACK = 2'd1;
   localparam logic [1:0] ST_NEG = 2'd2;
   localparam logic [1:0] ST_ERR = 2'd3;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   localparam int  CSR_ADDR_W = 3;
   localparam int  CSR_DATA_W = 32;
   localparam logic REG_CAPACITY = 1'b0;
   localparam logic REG_DELIVER  = 1'b1;
   localparam logic [7:0] CAPACITY_RESET = 8'd255;
   localparam logic       DELIVER_RESET  = 1'b1;

   typedef struct packed {
      logic [7:0] payload_capacity;
      logic       deliver_payload;
   } cfg_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] payload_byte;
      logic [7:0] payload_index;
      logic [1:0] status;
      logic [7:0] message_id;
      logic [7:0] delivered_length;
   } rsp_payload_type;

   // One byte through CRC-8, MSB first.
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in, input logic [7:0] data);
      logic [7:0] c;
      c = crc_in ^ data;
      for (int i = 0; i < 8; i++) begin
         c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
      end
      return c;
   endfunction

endpackage

[hdl/crc8pfc_req_if.sv]
interface crc8pfc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       last_byte;

   modport source (output valid, output rx_byte, output last_byte, input ready);
   modport sink (input valid, input rx_byte, input last_byte, output ready);
endinterface

[hdl/crc8pfc_rsp_if.sv]
interface crc8pfc_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] payload_byte;
   logic [7:0] payload_index;
   logic [1:0] status;
   logic [7:0] message_id;
   logic [7:0] delivered_length;

   modport source (output valid, output kind, output payload_byte, output payload_index,
                   output status, output message_id, output delivered_length, input ready);
   modport sink (input valid, input kind, input payload_byte, input payload_index,
                 input status, input message_id, input delivered_length, output ready);
endinterface

[hdl/crc8pfc_csr_regs.sv]
module crc8pfc_csr_regs
   import crc8pfc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   logic [7:0] capacity_ff, capacity_in;
   logic       deliver_ff, deliver_in;
   logic       wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      capacity_in = capacity_ff;
      deliver_in  = deliver_ff;
      if (wr_en) begin
         case (paddr[2])
            REG_CAPACITY: capacity_in = pwdata[7:0];
            REG_DELIVER:  deliver_in  = pwdata[0];
            default:      ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         capacity_ff <= CAPACITY_RESET;
         deliver_ff  <= DELIVER_RESET;
      end else begin
         capacity_ff <= capacity_in;
         deliver_ff  <= deliver_in;
      end
   end

   always_comb begin
      case (paddr[2])
         REG_CAPACITY: prdata = {{(CSR_DATA_W-8){1'b0}}, capacity_ff};
         REG_DELIVER:  prdata = {{(CSR_DATA_W-1){1'b0}}, deliver_ff};
         default:      prdata = '0;
      endcase
   end

   assign cfg.payload_capacity = capacity_ff;
   assign cfg.deliver_payload  = deliver_ff;

endmodule

[hdl/crc8pfc_frame_tracker.sv]
`include "crc8_packet_frame_checker_unit_assert.svh"

module crc8pfc_frame_tracker
   import crc8pfc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  cfg_type         cfg,
   input  logic            in_fire,
   input  logic [7:0]      rx_byte,
   input  logic            last_byte,
   output logic            res_valid,
   output rsp_payload_type res
);

   logic [8:0] byte_count_ff, byte_count_in;
   logic [7:0] first_header_ff, first_header_in;
   logic [7:0] second_header_ff, second_header_in;
   logic [7:0] frame_id_ff, frame_id_in;
   logic [7:0] frame_length_ff, frame_length_in;
   logic [7:0] running_crc_ff, running_crc_in;

   logic [7:0] hdr1_cur, hdr2_cur, id_cur, len_cur;
   logic [8:0] pay_pos;
   logic       full_stored;
   logic       emit;
   logic [9:0] total;
   logic [1:0] status;
   logic [7:0] mid;
   logic [7:0] dlen;

   // Header fields as they stand after this byte is captured.
   assign hdr1_cur = (byte_count_ff == 9'd0) ? rx_byte : first_header_ff;
   assign hdr2_cur = (byte_count_ff == 9'd1) ? rx_byte : second_header_ff;
   assign id_cur   = (byte_count_ff == 9'd2) ? rx_byte : frame_id_ff;
   assign len_cur  = (byte_count_ff == 9'd3) ? rx_byte : frame_length_ff;

   assign full_stored = (first_header_ff == HDR_FULL) && (second_header_ff == HDR_FULL);
   assign pay_pos     = byte_count_ff - PAYLOAD_START;
   assign emit = (byte_count_ff >= PAYLOAD_START) && full_stored && cfg.deliver_payload
              && (pay_pos < {1'b0, frame_length_ff})
              && (pay_pos < {1'b0, cfg.payload_capacity});

   assign total = {1'b0, byte_count_ff} + 10'd1;

   always_comb begin
      mid  = '0;
      dlen = '0;
      if (total < MIN_TOTAL) begin
         status = ST_ERR;
      end else if (hdr1_cur == HDR_ACK && hdr2_cur == HDR_ACK) begin
         status = ST_ACK;
      end else if (hdr1_cur == HDR_NEG && hdr2_cur == HDR_NEG) begin
         status = ST_NEG;
      end else if (hdr1_cur == HDR_FULL && hdr2_cur == HDR_FULL) begin
         if (total < FULL_MIN_TOTAL) begin
            status = ST_NEG;
         end else if (({2'b0, len_cur} + FULL_OVERHEAD) != total) begin
            status = ST_ERR;
         end else if (running_crc_ff != rx_byte) begin
            status = ST_ERR;
         end else begin
            status = ST_OK;
            mid    = id_cur;
            if (cfg.deliver_payload) begin
               dlen = (len_cur < cfg.payload_capacity) ? len_cur : cfg.payload_capacity;
            end
         end
      end else begin
         status = ST_ERR;
      end
   end

   always_comb begin
      res_valid = in_fire && (last_byte || emit);
      res       = '0;
      if (last_byte) begin
         res.kind             = KIND_STATUS;
         res.status           = status;
         res.message_id       = mid;
         res.delivered_length = dlen;
      end else begin
         res.kind          = KIND_PAYLOAD;
         res.payload_byte  = rx_byte;
         res.payload_index = pay_pos[7:0];
      end
   end

   always_comb begin
      byte_count_in    = byte_count_ff;
      first_header_in  = first_header_ff;
      second_header_in = second_header_ff;
      frame_id_in      = frame_id_ff;
      frame_length_in  = frame_length_ff;
      running_crc_in   = running_crc_ff;
      if (in_fire) begin
         if (last_byte) begin
            byte_count_in    = '0;
            first_header_in  = '0;
            second_header_in = '0;
            frame_id_in      = '0;
            frame_length_in  = '0;
            running_crc_in   = CRC_INIT;
         end else begin
            first_header_in  = hdr1_cur;
            second_header_in = hdr2_cur;
            frame_id_in      = id_cur;
            frame_length_in  = len_cur;
            running_crc_in   = crc8_byte(running_crc_ff, rx_byte);
            if (byte_count_ff != COUNT_MAX) begin
               byte_count_in = byte_count_ff + 9'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff    <= '0;
         first_header_ff  <= '0;
         second_header_ff <= '0;
         frame_id_ff      <= '0;
         frame_length_ff  <= '0;
         running_crc_ff   <= CRC_INIT;
      end else begin
         byte_count_ff    <= byte_count_in;
         first_header_ff  <= first_header_in;
         second_header_ff <= second_header_in;
         frame_id_ff      <= frame_id_in;
         frame_length_ff  <= frame_length_in;
         running_crc_ff   <= running_crc_in;
      end
   end

   `CRC8PFC_ASSERT(a_last_gives_status, (in_fire && last_byte) |-> res_valid, "last byte without status")
   `CRC8PFC_ASSERT(a_idle_no_result, (!in_fire) |-> (!res_valid), "result without a request")
   `CRC8PFC_ASSERT(a_clear_after_last, (in_fire && last_byte) |=> (byte_count_ff == 9'd0 && running_crc_ff == CRC_INIT), "frame state not cleared")
   `CRC8PFC_ASSERT(a_count_saturates, (in_fire && !last_byte && byte_count_ff == COUNT_MAX) |=> (byte_count_ff == COUNT_MAX), "byte count wrapped")

endmodule

[hdl/crc8pfc_out_buffer.sv]
`include "crc8_packet_frame_checker_unit_assert.svh"

module crc8pfc_out_buffer
   import crc8pfc_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  rsp_payload_type push_data,
   output logic            space,
   crc8pfc_rsp_if.source   rsp_chan
);

   logic            out_valid_ff, out_valid_in;
   logic            skid_valid_ff, skid_valid_in;
   rsp_payload_type out_data_ff, out_data_in;
   rsp_payload_type skid_data_ff, skid_data_in;
   logic            pop;

   assign pop   = out_valid_ff && rsp_chan.ready;
   assign space = !skid_valid_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (pop || !out_valid_ff) begin
         if (skid_valid_ff) begin
            // advance the skid entry; skid full means no push this cycle
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = push;
            out_data_in  = push_data;
         end
      end else if (push) begin
         skid_valid_in = 1'b1;
         skid_data_in  = push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_chan.valid            = out_valid_ff;
   assign rsp_chan.kind             = out_data_ff.kind;
   assign rsp_chan.payload_byte     = out_data_ff.payload_byte;
   assign rsp_chan.payload_index    = out_data_ff.payload_index;
   assign rsp_chan.status           = out_data_ff.status;
   assign rsp_chan.message_id       = out_data_ff.message_id;
   assign rsp_chan.delivered_length = out_data_ff.delivered_length;

   `CRC8PFC_ASSERT_ALWAYS(a_skid_behind_out, skid_valid_ff |-> out_valid_ff, "skid full with empty output")
   `CRC8PFC_ASSERT(a_no_push_when_full, push |-> (!skid_valid_ff), "push into full buffer")
   `CRC8PFC_ASSERT(a_skid_moves_up, (skid_valid_ff && pop) |=> (out_data_ff == $past(skid_data_ff)), "skid entry lost")

endmodule

[hdl/crc8_packet_frame_checker_unit.sv]
// Channel    Direction  Handshake      Payload
// req_chan   in         valid/ready    rx_byte[7:0], last_byte
// rsp_chan   out        valid/ready    kind, payload_byte, payload_index, status,
//                                      message_id, delivered_length
// csr (APB)  in/out     psel/penable   paddr[2:0], pwdata, prdata; pready tied high
//
// One request per cycle while req_chan.ready is high: header capture, CRC-8
// update and the end-of-frame checks all sit between the frame state
// registers and the output register; a request causes zero or one result.
// Reset (synchronous, active high) clears frame state and restores the
// registers to capacity 255 and deliver 1; no clearing pass is needed.
// A two-entry output buffer lets a request enter while a result waits;
// req_chan.ready drops only when both entries are held.
module crc8_packet_frame_checker_unit
   import crc8pfc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   crc8pfc_req_if.sink           req_chan,
   crc8pfc_rsp_if.source         rsp_chan,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   cfg_type         cfg;
   logic            in_fire;
   logic            buf_space;
   logic            res_valid;
   rsp_payload_type res;

   // accept whenever the output buffer has a free entry
   assign req_chan.ready = buf_space;
   assign in_fire        = req_chan.valid && buf_space;

   crc8pfc_csr_regs u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // frame state, CRC and status decision
   crc8pfc_frame_tracker u_tracker (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_fire   (in_fire),
      .rx_byte   (req_chan.rx_byte),
      .last_byte (req_chan.last_byte),
      .res_valid (res_valid),
      .res       (res)
   );

   // hold results until the consumer takes them
   crc8pfc_out_buffer u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (res_valid),
      .push_data (res),
      .space     (buf_space),
      .rsp_chan  (rsp_chan)
   );

endmodule

[verif/crc8_packet_frame_checker_unit_tb.sv]
`timescale 1ns / 1ps

module crc8_packet_frame_checker_unit_tb;
   import crc8pfc_pkg::*;

   // Where the byte of a stimulus row comes from: the row itself, or the CRC
   // that the frame has built up so far.
   typedef enum logic {BYTE_AS_GIVEN, BYTE_IS_CRC} row_byte_type;

   // How a generated full frame is damaged, if at all.
   typedef enum logic [1:0] {FLAW_NONE, FLAW_BAD_CRC, FLAW_CUT, FLAW_OVERRUN} frame_flaw_type;

   typedef logic [7:0] byte_q_type[$];

   typedef struct packed {
      logic [7:0]      rx;
      logic            last;
      row_byte_type    src;
      logic            pinned;
      rsp_payload_type pin;
   } stim_row_type;

   localparam rsp_payload_type NO_RSP  = '0;
   localparam rsp_payload_type END_ERR = '{KIND_STATUS, 8'h00, 8'h00, ST_ERR, 8'h00, 8'h00};
   localparam rsp_payload_type END_ACK = '{KIND_STATUS, 8'h00, 8'h00, ST_ACK, 8'h00, 8'h00};
   localparam rsp_payload_type END_NEG = '{KIND_STATUS, 8'h00, 8'h00, ST_NEG, 8'h00, 8'h00};
   localparam rsp_payload_type END_OK_FF1 =
      '{KIND_STATUS, 8'h00, 8'h00, ST_OK, 8'hFF, 8'h01};

   // Directed frames, sent with the reset register values (capacity 255,
   // delivery on). Rows with a pinned result are checked against that value;
   // the rest go through the frame tracker.
   localparam int DIRECTED_ROWS = 23;
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      // one-byte frame: too short
      '{8'h00, 1'b1, BYTE_AS_GIVEN, 1'b1, END_ERR},
      // ack frame
      '{8'hA0, 1'b0, BYTE_AS_GIVEN, 1'b0, NO_RSP},
      '{8'hA0, 1'b1, BYTE_AS_GIVEN, 1'b1, END_ACK},
      // neg frame with a trailing byte
      '{8'hB0, 1'b0, BYTE_AS_GIVEN, 1'b0, NO_RSP},
      '{8'hB0, 1'b0, BYTE_AS_GIVEN, 1'b0, NO_RSP},
      '{8'h00, 1'b1, BYTE_AS_GIVEN, 1'b1, END_NEG},
      // unknown header pair
      '{8'h55, 1'b0, BYTE_AS_GIVEN, 1'b0, NO_RSP},
      '{8'hAA, 1'b1, BYTE_AS_GIVEN, 1'b1, END_ERR},
      // full header but under six bytes
      '{8'hF0, 1'b0, BYTE_AS_GIVEN, 1'b0, NO_RSP},
      '{8'hF0, 1'b0, BYTE_AS_GIVEN, 1'b0, NO_RSP},
      '{8'h12, 1'b1, BYTE_AS_GIVEN, 1'b1, END_NEG},
      // good full frame: id FF, one payload byte FF
      '{8'hF0, 1'b0, BYTE_AS_GIVEN, 1'b0, NO_RSP},
      '{8'hF0, 1'b0, BYTE_AS_GIVEN, 1'b0, NO_RSP},
      '{8'hFF, 1'b0, BYTE_AS_GIVEN, 1'b0, NO_RSP},
      '{8'h01, 1'b0, BYTE_AS_GIVEN, 1'b0, NO_RSP},
      '{8'hFF, 1'b0, BYTE_AS_GIVEN, 1'b0, NO_RSP},
      '{8'h00, 1'b1, BYTE_IS_CRC,   1'b1, END_OK_FF1},
      // zero-length payload followed by a stray byte: never emitted, ends in error
      '{8'hF0, 1'b0, BYTE_AS_GIVEN, 1'b0, NO_RSP},
      '{8'hF0, 1'b0, BYTE_AS_GIVEN, 1'b0, NO_RSP},
      '{8'h00, 1'b0, BYTE_AS_GIVEN, 1'b0, NO_RSP},
      '{8'h00, 1'b0, BYTE_AS_GIVEN, 1'b0, NO_RSP},
      '{8'h00, 1'b0, BYTE_AS_GIVEN, 1'b0, NO_RSP},
      '{8'h00, 1'b1, BYTE_IS_CRC,   1'b1, END_ERR}
   };

   logic clock;
   logic reset;

   crc8pfc_req_if req_bus();
   crc8pfc_rsp_if rsp_bus();

   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   crc8_packet_frame_checker_unit uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .psel     (psel),
      .penable  (penable),
      .pwrite   (pwrite),
      .paddr    (paddr),
      .pwdata   (pwdata),
      .prdata   (prdata),
      .pready   (pready)
   );

   // Register copies, as last written over the APB port.
   logic [7:0] cap_cfg;
   logic       deliver_cfg;

   // Frame state as the block should hold it between requests.
   logic [8:0] rx_count;
   logic [7:0] hdr_a;
   logic [7:0] hdr_b;
   logic [7:0] frame_tag;
   logic [7:0] frame_len;
   logic [7:0] crc_run;

   rsp_payload_type rsp_backlog[$];
   int              sent_count;
   int              bad_rsp_count;
   bit              no_idle;
   int              hold_asks;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop well past the slowest clean run.
   initial begin
      #2000000;
      $display("crc8_packet_frame_checker_unit_tb: done, errors");
      $finish;
   end

   // CRC-8, polynomial 0x31, MSB first: shift one byte into the accumulator.
   function automatic logic [7:0] crc8_next(input logic [7:0] acc, input logic [7:0] d);
      logic [7:0] c;
      c = acc ^ d;
      for (int k = 0; k < 8; k++)
         c = {c[6:0], 1'b0} ^ (c[7] ? CRC_POLY : 8'h00);
      return c;
   endfunction

   // Advance the frame state by one accepted request. Return 1 with the result
   // in r when the request produces one.
   function automatic bit track_rx_byte(input logic [7:0] b, input logic last,
                                        output rsp_payload_type r);
      logic [8:0] pos;
      logic [8:0] p;
      logic [9:0] total;
      bit         full;
      pos = rx_count;
      r = '0;
      case (pos)
         9'd0: hdr_a = b;
         9'd1: hdr_b = b;
         9'd2: frame_tag = b;
         9'd3: frame_len = b;
         default: ;
      endcase
      full = (hdr_a == HDR_FULL) && (hdr_b == HDR_FULL);

      if (!last) begin
         crc_run = crc8_next(crc_run, b);
         // hold the count at its ceiling on runaway frames
         if (rx_count != COUNT_MAX)
            rx_count = rx_count + 9'd1;
         if (pos >= PAYLOAD_START && full && deliver_cfg) begin
            p = pos - PAYLOAD_START;
            if (p < {1'b0, frame_len} && p < {1'b0, cap_cfg}) begin
               r.kind = KIND_PAYLOAD;
               r.payload_byte = b;
               r.payload_index = p[7:0];
               return 1'b1;
            end
         end
         return 1'b0;
      end

      total = {1'b0, pos} + 10'd1;
      r.kind = KIND_STATUS;
      if (total < MIN_TOTAL) begin
         r.status = ST_ERR;
      end else if (hdr_a == HDR_ACK && hdr_b == HDR_ACK) begin
         r.status = ST_ACK;
      end else if (hdr_a == HDR_NEG && hdr_b == HDR_NEG) begin
         r.status = ST_NEG;
      end else if (full) begin
         if (total < FULL_MIN_TOTAL)
            r.status = ST_NEG;
         else if ({2'b00, frame_len} + FULL_OVERHEAD != total)
            r.status = ST_ERR;
         else if (crc_run != b)
            r.status = ST_ERR;
         else begin
            r.status = ST_OK;
            r.message_id = frame_tag;
            if (deliver_cfg)
               r.delivered_length = (frame_len < cap_cfg) ? frame_len : cap_cfg;
         end
      end else begin
         r.status = ST_ERR;
      end

      // drop all frame state after the end status
      rx_count  = '0;
      hdr_a     = '0;
      hdr_b     = '0;
      frame_tag = '0;
      frame_len = '0;
      crc_run   = CRC_INIT;
      return 1'b1;
   endfunction

   // Offer one request, starting at a falling edge, and return at the falling
   // edge after it was taken. A pinned result replaces the tracked one.
   task automatic offer_byte(input logic [7:0] b, input logic last,
                             input bit pinned = 1'b0, input rsp_payload_type pin = '0);
      rsp_payload_type r;
      bit              has;
      while (!no_idle && $urandom_range(99) < 12) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.rx_byte   <= b;
      req_bus.last_byte <= last;
      do @(posedge clock); while (!req_bus.ready);
      has = track_rx_byte(b, last, r);
      if (pinned)
         rsp_backlog.push_back(pin);
      else if (has)
         rsp_backlog.push_back(r);
      sent_count++;
      @(negedge clock);
   endtask

   task automatic send_run(input byte_q_type q, input bit close);
      for (int i = 0; i < q.size(); i++)
         offer_byte(q[i], close && (i == q.size() - 1));
   endtask

   // Full frame with random id and payload; extra bytes go past the declared
   // payload. Uncut frames close on the tracked CRC, damaged for FLAW_BAD_CRC.
   task automatic send_full_frame(input logic [7:0] len, input frame_flaw_type flaw,
                                  input int extra);
      byte_q_type q;
      int         cut;
      logic [7:0] tail;
      q = {HDR_FULL, HDR_FULL, 8'($urandom), len};
      repeat (int'(len) + extra) q.push_back(8'($urandom));
      if (flaw == FLAW_CUT) begin
         // end the frame early, anywhere after the first byte
         cut = $urandom_range(q.size() - 1, 1);
         q = q[0:cut];
         send_run(q, 1'b1);
      end else begin
         send_run(q, 1'b0);
         tail = crc_run;
         if (flaw == FLAW_BAD_CRC)
            tail = tail ^ 8'($urandom_range(255, 1));
         offer_byte(tail, 1'b1);
      end
   endtask

   // Mostly well-formed full frames; the rest are ack, neg and noise frames.
   task automatic send_random_frame();
      int         pick;
      int         shape;
      int         n;
      logic [7:0] len;
      logic [7:0] hdr;
      byte_q_type q;
      pick = $urandom_range(99);
      if (pick < 70) begin
         len = ($urandom_range(49) == 0) ? 8'($urandom_range(60, 13))
                                         : 8'($urandom_range(12, 0));
         shape = $urandom_range(99);
         if (shape < 10)
            send_full_frame(len, FLAW_BAD_CRC, 0);
         else if (shape < 18)
            send_full_frame(len, FLAW_CUT, 0);
         else if (shape < 25)
            send_full_frame(len, FLAW_OVERRUN, $urandom_range(4, 1));
         else
            send_full_frame(len, FLAW_NONE, 0);
      end else if (pick < 86) begin
         hdr = (pick < 78) ? HDR_ACK : HDR_NEG;
         q = {hdr, hdr};
         n = $urandom_range(3, 0);
         repeat (n) q.push_back(8'($urandom));
         send_run(q, 1'b1);
      end else begin
         n = $urandom_range(8, 1);
         repeat (n) q.push_back(8'($urandom));
         if ($urandom_range(1)) begin
            case ($urandom_range(2))
               0: q[0] = HDR_ACK;
               1: q[0] = HDR_NEG;
               default: q[0] = HDR_FULL;
            endcase
         end
         send_run(q, 1'b1);
      end
   endtask

   // APB write: setup cycle, then access cycle; starts and ends at a falling edge.
   task automatic csr_write(input logic reg_sel, input logic [CSR_DATA_W-1:0] data);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {reg_sel, 2'b00};
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (reg_sel == REG_CAPACITY)
         cap_cfg = data[7:0];
      else
         deliver_cfg = data[0];
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      @(negedge clock);
   endtask

   // Drain every outstanding result, let the pipeline empty, then reprogram.
   task automatic settle_and_configure(input logic [7:0] cap, input logic deliver);
      req_bus.valid <= 1'b0;
      wait (rsp_backlog.size() == 0);
      repeat (4) @(negedge clock);
      csr_write(REG_CAPACITY, {24'h0, cap});
      csr_write(REG_DELIVER, {31'h0, deliver});
   endtask

   // Result side: random back-pressure, plus a long hold-off on request.
   initial begin : rsp_pacing
      int hold_left;
      int holds_served;
      hold_left = 0;
      holds_served = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (holds_served != hold_asks) begin
            holds_served = hold_asks;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else if (no_idle) begin
            rsp_bus.ready <= 1'b1;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= 12);
         end
      end
   end

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         bad_rsp_count++;
      end
   endtask

   // Compare every taken result with the oldest outstanding one.
   always @(posedge clock) begin : rsp_watch
      rsp_payload_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (rsp_backlog.size() == 0) begin
            $error("result taken with none outstanding");
            bad_rsp_count++;
         end else begin
            want = rsp_backlog.pop_front();
            check_field("kind", want.kind, rsp_bus.kind);
            check_field("payload_byte", want.payload_byte, rsp_bus.payload_byte);
            check_field("payload_index", want.payload_index, rsp_bus.payload_index);
            check_field("status", want.status, rsp_bus.status);
            check_field("message_id", want.message_id, rsp_bus.message_id);
            check_field("delivered_length", want.delivered_length,
                        rsp_bus.delivered_length);
         end
      end
   end

   initial begin : stimulus
      logic [7:0] b;
      int         phase_base;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.rx_byte   = 8'h00;
      req_bus.last_byte = 1'b0;
      psel              = 1'b0;
      penable           = 1'b0;
      pwrite            = 1'b0;
      paddr             = '0;
      pwdata            = '0;
      cap_cfg           = CAPACITY_RESET;
      deliver_cfg       = DELIVER_RESET;
      rx_count          = '0;
      hdr_a             = '0;
      hdr_b             = '0;
      frame_tag         = '0;
      frame_len         = '0;
      crc_run           = CRC_INIT;
      sent_count        = 0;
      bad_rsp_count     = 0;
      no_idle           = 1'b0;
      hold_asks         = 0;
      phase_base        = 0;
      repeat (2) @(negedge clock);
      reset <= 1'b0;

      // Reset values first: directed frames, then the widest payload.
      settle_and_configure(CAPACITY_RESET, DELIVER_RESET);
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         b = (DIRECTED[i].src == BYTE_IS_CRC) ? crc_run : DIRECTED[i].rx;
         offer_byte(b, DIRECTED[i].last, DIRECTED[i].pinned, DIRECTED[i].pin);
      end
      send_full_frame(8'd255, FLAW_NONE, 0);
      while (sent_count < 350) send_random_frame();

      // No payload room at all.
      settle_and_configure(8'd0, 1'b1);
      while (sent_count < 600) send_random_frame();

      // Status only; push one frame past the byte counter ceiling.
      settle_and_configure(8'd255, 1'b0);
      send_full_frame(8'($urandom_range(31, 0)), FLAW_OVERRUN, 520);
      while (sent_count < 1150) send_random_frame();

      // Small capacity, no idling, and a long result hold-off so the output
      // buffer fills and back-pressures the request side.
      settle_and_configure(8'd3, 1'b1);
      no_idle = 1'b1;
      hold_asks++;
      phase_base = sent_count;
      while (sent_count < phase_base + 200) send_random_frame();
      no_idle = 1'b0;

      settle_and_configure(8'd128, 1'b1);
      phase_base = sent_count;
      while (sent_count < phase_base + 150) send_random_frame();

      settle_and_configure(8'($urandom_range(254, 1)), 1'($urandom_range(1)));
      phase_base = sent_count;
      while (sent_count < phase_base + 200) send_random_frame();

      req_bus.valid <= 1'b0;
      wait (rsp_backlog.size() == 0);
      repeat (10) @(posedge clock);
      if (bad_rsp_count == 0)
         $display("crc8_packet_frame_checker_unit_tb: done, clean");
      else
         $display("crc8_packet_frame_checker_unit_tb: done, errors");
      $finish;
   end

endmodule

[filelist.f]
+incdir+hdl
hdl/crc8pfc_pkg.sv
hdl/crc8pfc_req_if.sv
hdl/crc8pfc_rsp_if.sv
hdl/crc8pfc_csr_regs.sv
hdl/crc8pfc_frame_tracker.sv
hdl/crc8pfc_out_buffer.sv
hdl/crc8_packet_frame_checker_unit.sv
verif/crc8_packet_frame_checker_unit_tb.sv
